[hw/rtl/ecis_pkg.sv]
package ecis_pkg;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RDW,
      S_FETCH,
      S_B1,
      S_B1W,
      S_B2W,
      S_EXEC,
      S_DW,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      ITEM_EXEC  = 2'd0,
      ITEM_WRITE = 2'd1,
      ITEM_READ  = 2'd2,
      ITEM_NONE  = 2'd3
   } item_type;

   localparam int REG_COUNT = 8;

   localparam logic [3:0] OPC_LDW  = 4'd0;
   localparam logic [3:0] OPC_STW  = 4'd1;
   localparam logic [3:0] OPC_MVW  = 4'd2;
   localparam logic [3:0] OPC_ADD  = 4'd3;
   localparam logic [3:0] OPC_ADC  = 4'd4;
   localparam logic [3:0] OPC_SUB  = 4'd5;
   localparam logic [3:0] OPC_SBB  = 4'd6;
   localparam logic [3:0] OPC_INC  = 4'd7;
   localparam logic [3:0] OPC_CMP  = 4'd8;
   localparam logic [3:0] OPC_JNZ  = 4'd9;
   localparam logic [3:0] OPC_PUSH = 4'd10;
   localparam logic [3:0] OPC_POP  = 4'd11;
   localparam logic [3:0] OPC_BSL  = 4'd12;
   localparam logic [3:0] OPC_BSR  = 4'd13;
   localparam logic [3:0] OPC_OUT  = 4'd14;
   localparam logic [3:0] OPC_HALT = 4'd15;

   localparam logic [2:0] R_A   = 3'd0;
   localparam logic [2:0] R_B   = 3'd1;
   localparam logic [2:0] R_C   = 3'd2;
   localparam logic [2:0] R_D   = 3'd3;
   localparam logic [2:0] R_HFP = 3'd4;
   localparam logic [2:0] R_LFP = 3'd5;
   localparam logic [2:0] R_SP  = 3'd6;
   localparam logic [2:0] R_F   = 3'd7;

   localparam int F_POS    = 7;
   localparam int F_CARRY  = 6;
   localparam int F_EQ     = 5;
   localparam int F_ZERO   = 4;
   localparam int F_LESS   = 3;
   localparam int F_BORROW = 2;
   localparam int F_NEG    = 1;
   localparam int F_OVF    = 0;

endpackage

[hw/rtl/eight_bit_cpu_instruction_step_core.sv]
// one item at a time; the single-port byte memory (one access per cycle) sets the
// order of steps: fetch, operand bytes, data access, execute
// a new request is taken while the previous result still waits in the output register
// reset: synchronous; registers and halt clear at once, then a clearing pass writes
// zero to all 2**MEM_ADDR_BITS memory bytes, one per cycle, before the first request
module eight_bit_cpu_instruction_step_core #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [15:0]       req_addr,
   input  logic [7:0]        req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_out_valid,
   output logic signed [8:0] rsp_out_value,
   output logic              rsp_halted,
   output logic [15:0]       rsp_pc_after,
   output logic [7:0]        rsp_flags,
   output logic [7:0]        rsp_read_data,
   output logic [4:0]        rsp_step_cycles
);
   import ecis_pkg::*;

   localparam int AW = MEM_ADDR_BITS;
   localparam int DEPTH = 1 << AW;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdq_ff;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [7:0] regs_ff [REG_COUNT];
   logic [7:0] regs_in [REG_COUNT];
   logic halt_ff, halt_in;
   logic [15:0] pc_ff, pc_in;
   logic [15:0] old_ff, old_in;
   logic [7:0] ins_ff, ins_in, b1_ff, b1_in, b2_ff, b2_in;
   logic ovr_v_ff, ovr_v_in;
   logic [7:0] ovr_b_ff, ovr_b_in;
   logic outv_ff, outv_in;
   logic [8:0] outval_ff, outval_in;
   logic [7:0] rd_ff, rd_in;
   logic [4:0] cyc_ff, cyc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_out_valid_ff, rsp_out_valid_in;
   logic [8:0] rsp_out_value_ff, rsp_out_value_in;
   logic rsp_halted_ff, rsp_halted_in;
   logic [15:0] rsp_pc_ff, rsp_pc_in;
   logic [7:0] rsp_flags_ff, rsp_flags_in;
   logic [7:0] rsp_rd_ff, rsp_rd_in;
   logic [4:0] rsp_cyc_ff, rsp_cyc_in;

   logic mem_re, mem_we;
   logic [15:0] mem_ra, mem_wa;
   logic [7:0] mem_wd;
   logic [AW-1:0] ra_idx, wa_idx;
   logic [7:0] rd_data;

   logic [3:0] opc;
   logic mode;
   logic [2:0] r0;
   logic [7:0] x, y, yf, cin;
   logic [9:0] res;
   logic [15:0] ab, cd, fp, word, xw, ww;
   logic [7:0] fl, w8, sp_new;
   logic need_b2, taken;

   assign ra_idx = mem_ra[AW-1:0];
   assign wa_idx = mem_wa[AW-1:0];
   assign rd_data = ovr_v_ff ? ovr_b_ff : rdq_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wa_idx] <= mem_wd;
      end
      if (mem_re) begin
         rdq_ff <= mem[ra_idx];
      end
   end

   assign opc  = ins_ff[7:4];
   assign mode = ins_ff[3];
   assign r0   = ins_ff[2:0];
   assign ab   = {regs_ff[R_A], regs_ff[R_B]};
   assign cd   = {regs_ff[R_C], regs_ff[R_D]};
   assign fp   = {regs_ff[R_HFP], regs_ff[R_LFP]};
   assign word = {b1_ff, b2_ff};
   assign x    = regs_ff[r0];
   assign sp_new = regs_ff[R_SP] + 8'd1;
   assign taken = !regs_ff[R_F][F_ZERO];

   always_comb begin
      need_b2 = 1'b0;
      unique case (opc)
         OPC_LDW, OPC_STW: need_b2 = !mode;
         OPC_JNZ:          need_b2 = !mode && taken;
         OPC_PUSH, OPC_POP: need_b2 = mode;
         default:          need_b2 = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      for (int i = 0; i < REG_COUNT; i++) begin
         regs_in[i] = regs_ff[i];
      end
      halt_in = halt_ff;
      pc_in = pc_ff;
      old_in = old_ff;
      ins_in = ins_ff;
      b1_in = b1_ff;
      b2_in = b2_ff;
      outv_in = outv_ff;
      outval_in = outval_ff;
      rd_in = rd_ff;
      cyc_in = cyc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_out_valid_in = rsp_out_valid_ff;
      rsp_out_value_in = rsp_out_value_ff;
      rsp_halted_in = rsp_halted_ff;
      rsp_pc_in = rsp_pc_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_rd_in = rsp_rd_ff;
      rsp_cyc_in = rsp_cyc_ff;
      mem_re = 1'b0;
      mem_ra = 16'd0;
      mem_we = 1'b0;
      mem_wa = 16'd0;
      mem_wd = 8'd0;
      req_ready = 1'b0;
      y = 8'd0;
      yf = 8'd0;
      cin = 8'd0;
      res = 10'd0;
      fl = 8'd0;
      xw = 16'd0;
      ww = 16'd0;
      w8 = 8'd0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = 16'(clr_ff);
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               outv_in = 1'b0;
               outval_in = 9'd0;
               rd_in = 8'd0;
               cyc_in = 5'd0;
               old_in = pc_ff;
               state_in = S_DONE;
               unique case (item_type'(req_op))
                  ITEM_WRITE: begin
                     mem_we = 1'b1;
                     mem_wa = req_addr;
                     mem_wd = req_data;
                  end
                  ITEM_READ: begin
                     mem_re = 1'b1;
                     mem_ra = req_addr;
                     state_in = S_RDW;
                  end
                  ITEM_EXEC: begin
                     if (!halt_ff) begin
                        mem_re = 1'b1;
                        mem_ra = pc_ff;
                        state_in = S_FETCH;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RDW: begin
            rd_in = rd_data;
            state_in = S_DONE;
         end
         S_FETCH: begin
            ins_in = rd_data;
            state_in = S_B1;
            unique case (rd_data[7:4])
               OPC_LDW, OPC_STW: begin
                  pc_in = old_ff + (rd_data[3] ? 16'd1 : 16'd3);
                  if (rd_data[3]) begin
                     state_in = S_EXEC;
                  end
               end
               OPC_MVW: begin
                  pc_in = old_ff + 16'd2;
               end
               OPC_PUSH, OPC_POP: begin
                  pc_in = old_ff + (rd_data[3] ? 16'd3 : 16'd1);
                  if (!rd_data[3]) begin
                     state_in = S_EXEC;
                  end
               end
               OPC_INC, OPC_BSL, OPC_BSR, OPC_OUT, OPC_HALT: state_in = S_EXEC;
               OPC_JNZ: begin
                  if (rd_data[3] || !taken) begin
                     state_in = S_EXEC;
                  end
               end
               default: state_in = S_B1;
            endcase
         end
         S_B1: begin
            mem_re = 1'b1;
            mem_ra = old_ff + 16'd1;
            state_in = S_B1W;
         end
         S_B1W: begin
            b1_in = rd_data;
            if (need_b2) begin
               mem_re = 1'b1;
               mem_ra = old_ff + 16'd2;
               state_in = S_B2W;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_B2W: begin
            b2_in = rd_data;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            y = mode ? b1_ff : regs_ff[b1_ff[2:0]];
            unique case (opc)
               OPC_LDW: begin
                  cyc_in = 5'd5;
                  mem_re = 1'b1;
                  mem_ra = mode ? ab : word;
                  state_in = S_DW;
               end
               OPC_STW: begin
                  cyc_in = 5'd5;
                  mem_we = 1'b1;
                  mem_wa = mode ? ab : word;
                  mem_wd = x;
               end
               OPC_MVW: begin
                  cyc_in = 5'd4;
                  regs_in[r0] = y;
               end
               OPC_ADD, OPC_ADC, OPC_SUB, OPC_SBB, OPC_INC: begin
                  if (opc == OPC_INC) begin
                     cyc_in = 5'd18;
                     pc_in = old_ff + 16'd1;
                     yf = mode ? 8'hFF : 8'h01;
                     res = {2'b00, x} + (mode ? 10'h3FF : 10'd1);
                  end else begin
                     cyc_in = 5'd9;
                     pc_in = old_ff + 16'd2;
                     yf = y;
                     if (opc == OPC_ADC) begin
                        cin = {7'd0, regs_ff[R_F][F_CARRY]};
                     end else if (opc == OPC_SBB) begin
                        cin = {7'd0, regs_ff[R_F][F_BORROW]};
                     end
                     if (opc == OPC_ADD || opc == OPC_ADC) begin
                        res = {2'b00, x} + {2'b00, y} + {2'b00, cin};
                     end else begin
                        res = {2'b00, x} - {2'b00, y} - {2'b00, cin};
                     end
                  end
                  fl[F_ZERO] = (res[7:0] == 8'd0);
                  fl[F_OVF] = !(x[7] ^ yf[7]) && (x[7] ^ res[7]);
                  fl[F_CARRY] = !res[9] && res[8];
                  fl[F_BORROW] = res[9];
                  fl[F_POS] = !res[7];
                  fl[F_NEG] = res[7];
                  regs_in[r0] = res[7:0];
                  regs_in[R_F] = fl;
               end
               OPC_CMP: begin
                  cyc_in = 5'd8;
                  pc_in = old_ff + 16'd2;
                  fl[F_ZERO] = (x == 8'd0);
                  fl[F_EQ] = (x == y);
                  fl[F_LESS] = (x < y);
                  fl[F_POS] = !x[7];
                  fl[F_NEG] = x[7] || (x == 8'd0);
                  regs_in[R_F] = fl;
               end
               OPC_JNZ: begin
                  cyc_in = 5'd4;
                  if (taken) begin
                     pc_in = mode ? ((r0 == 3'd0) ? ab : cd) : word;
                  end else begin
                     pc_in = old_ff + (mode ? 16'd1 : 16'd3);
                  end
               end
               OPC_PUSH: begin
                  regs_in[R_SP] = sp_new;
                  if (!mode) begin
                     cyc_in = 5'd8;
                     mem_we = 1'b1;
                     mem_wa = fp - {8'd0, sp_new};
                     mem_wd = (r0 == R_SP) ? sp_new : x;
                  end else begin
                     cyc_in = 5'd10;
                     mem_re = 1'b1;
                     mem_ra = word;
                     state_in = S_DW;
                  end
               end
               OPC_POP: begin
                  cyc_in = mode ? 5'd10 : 5'd8;
                  mem_re = 1'b1;
                  mem_ra = fp - {8'd0, regs_ff[R_SP]};
                  state_in = S_DW;
               end
               OPC_BSL, OPC_BSR: begin
                  cyc_in = 5'd6;
                  pc_in = old_ff + 16'd1;
                  if (!mode) begin
                     fl[F_CARRY] = (opc == OPC_BSL) ? x[7] : x[0];
                     w8 = (opc == OPC_BSL) ? {x[6:0], 1'b0} : {1'b0, x[7:1]};
                     fl[F_ZERO] = (w8 == 8'd0);
                     regs_in[r0] = w8;
                  end else begin
                     xw = (r0 == 3'd0) ? ab : cd;
                     fl[F_CARRY] = (opc == OPC_BSL) ? xw[15] : xw[0];
                     ww = (opc == OPC_BSL) ? {xw[14:0], 1'b0} : {1'b0, xw[15:1]};
                     fl[F_ZERO] = (ww == 16'd0);
                     if (r0 == 3'd0) begin
                        regs_in[R_A] = ww[15:8];
                        regs_in[R_B] = ww[7:0];
                     end else begin
                        regs_in[R_C] = ww[15:8];
                        regs_in[R_D] = ww[7:0];
                     end
                  end
                  regs_in[R_F] = fl;
               end
               OPC_OUT: begin
                  cyc_in = 5'd4;
                  pc_in = old_ff + 16'd1;
                  outv_in = 1'b1;
                  outval_in = {mode, x};
               end
               OPC_HALT: begin
                  cyc_in = 5'd1;
                  halt_in = 1'b1;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DW: begin
            state_in = S_DONE;
            unique case (opc)
               OPC_LDW: regs_in[r0] = rd_data;
               OPC_PUSH: begin
                  mem_we = 1'b1;
                  mem_wa = fp - {8'd0, regs_ff[R_SP]};
                  mem_wd = rd_data;
               end
               OPC_POP: begin
                  if (!mode) begin
                     regs_in[r0] = rd_data;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = word;
                     mem_wd = rd_data;
                  end
                  regs_in[R_SP] = regs_in[R_SP] - 8'd1;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_out_valid_in = outv_ff;
               rsp_out_value_in = outval_ff;
               rsp_halted_in = halt_ff;
               rsp_pc_in = pc_ff;
               rsp_flags_in = regs_ff[R_F];
               rsp_rd_in = rd_ff;
               rsp_cyc_in = cyc_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // memory writes to the program counter bytes land in the shadow copy
      if (mem_we && state_ff != S_CLEAR) begin
         if (wa_idx == AW'(0)) begin
            pc_in[15:8] = mem_wd;
         end else if (wa_idx == AW'(1)) begin
            pc_in[7:0] = mem_wd;
         end
      end

      // reads of the program counter bytes see the shadow copy
      ovr_v_in = mem_re && (ra_idx == AW'(0) || ra_idx == AW'(1));
      ovr_b_in = (ra_idx == AW'(0)) ? pc_ff[15:8] : pc_ff[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         regs_ff[R_A] <= 8'd0;
         regs_ff[R_B] <= 8'd0;
         regs_ff[R_C] <= 8'd0;
         regs_ff[R_D] <= 8'd0;
         regs_ff[R_HFP] <= 8'hFF;
         regs_ff[R_LFP] <= 8'hFF;
         regs_ff[R_SP] <= 8'hFF;
         regs_ff[R_F] <= 8'd0;
         halt_ff <= 1'b0;
         pc_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
         ovr_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= regs_in[i];
         end
         halt_ff <= halt_in;
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         ovr_v_ff <= ovr_v_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff <= old_in;
      ins_ff <= ins_in;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      ovr_b_ff <= ovr_b_in;
      outv_ff <= outv_in;
      outval_ff <= outval_in;
      rd_ff <= rd_in;
      cyc_ff <= cyc_in;
      rsp_out_valid_ff <= rsp_out_valid_in;
      rsp_out_value_ff <= rsp_out_value_in;
      rsp_halted_ff <= rsp_halted_in;
      rsp_pc_ff <= rsp_pc_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_rd_ff <= rsp_rd_in;
      rsp_cyc_ff <= rsp_cyc_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_value = $signed(rsp_out_value_ff);
   assign rsp_halted = rsp_halted_ff;
   assign rsp_pc_after = rsp_pc_ff;
   assign rsp_flags = rsp_flags_ff;
   assign rsp_read_data = rsp_rd_ff;
   assign rsp_step_cycles = rsp_cyc_ff;

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      $past(halt_ff) && !$past(reset) |-> halt_ff)
      else $error("halt flag cleared without reset");

   a_data_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DW |-> $past(state_ff) == S_EXEC)
      else $error("data access without execute step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside completion");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule
